// ===== rtl/tcce_pkg.sv =====
// Shared types and constants of the text console cell engine.
package tcce_pkg;

	// Item kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Register indexes on the config port
	localparam logic [1:0] REG_ATTRIBUTE    = 2'd0;
	localparam logic [1:0] REG_COLUMNS      = 2'd1;
	localparam logic [1:0] REG_ROWS         = 2'd2;
	localparam logic [1:0] REG_CURSOR_SHOWN = 2'd3;

	// Character codes
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam int TAB_STEP = 8;

	localparam logic [7:0]  RESET_ATTRIBUTE = 8'h0F;
	localparam logic [6:0]  RESET_COLUMNS   = 7'd80;
	localparam logic [4:0]  RESET_ROWS      = 5'd25;
	localparam logic [15:0] RESET_CELL      = {RESET_ATTRIBUTE, CH_SPACE};

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} req_word_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [10:0] cursor_position;
		logic        cursor_visible;
	} rsp_word_t;

endpackage

// ===== rtl/tcce_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/text_console_cell_engine_core.sv =====
// Top level of the text console cell engine: cell store, cursor and sequencer.
//
// Text screen of 16-bit cells (attribute in the high byte, character in the low
// byte) held in one synchronous RAM of CELL_COUNT entries, plus a cursor. Each
// request word is a put, a read or a clear and yields exactly one response word
// carrying the read cell (zero unless a read), the cursor's linear position
// row*columns+column (low 11 bits) and the cursor_shown flag. A read, an
// ordinary put or a control code is accepted, then executed, with the RAM read
// landing and the cell write going out in execute. A put that runs the cursor
// off the last row scrolls: the sequencer streams the store one cell a cycle,
// reading cell i+columns and writing cell i in the following cycle, and
// then blanks the new bottom line. A clear walks all CELL_COUNT cells. After
// reset the store is filled with blank cells (0x0F20) in one pass, during
// which req_ready stays low; config writes are taken throughout. The block
// works on one word at a time but accepts the next word while the previous
// response still waits in the output register. Out-of-range columns or rows
// act as the nearest legal value; a cursor left outside the geometry by a
// config change is pulled onto the last column/row at the next word.
module text_console_cell_engine_core #(
	parameter int CELL_COUNT  = 2048,
	parameter int MAX_COLUMNS = 80,
	parameter int MAX_ROWS    = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tcce_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tcce_pkg::rsp_word_t rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata
);

	import tcce_pkg::*;

	localparam int ADDR_W  = $clog2(CELL_COUNT);
	localparam int CW      = $clog2(MAX_COLUMNS);
	localparam int NCW     = $clog2(MAX_COLUMNS + 1);
	localparam int RW      = $clog2(MAX_ROWS);
	localparam int NRW     = $clog2(MAX_ROWS + 1);
	localparam int LIN_RAW = $clog2(MAX_ROWS * MAX_COLUMNS + MAX_COLUMNS + CELL_COUNT + 1);
	// linear addresses and pointers; at least 12 bits so the 11-bit position slices cleanly
	localparam int LIN_W   = (LIN_RAW > 12) ? LIN_RAW : 12;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	state_t state_q;

	// config registers
	logic [7:0] cfg_attr_q;
	logic [6:0] cfg_cols_q;
	logic [4:0] cfg_rows_q;
	logic       cfg_shown_q;

	// cursor, always inside the geometry once a word is in flight
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// current word
	logic [1:0]       kind_q;
	logic [7:0]       code_q;
	logic             rd_oob_q;
	logic [15:0]      data_q;
	logic [LIN_W-1:0] span_q;
	logic [LIN_W-1:0] ptr_q;

	// scroll write stage, which trails the read by one register
	logic             s1_vld;
	logic [LIN_W-1:0] addr_s1;
	logic             copy_s1;
	logic             oob_s1;

	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	// effective geometry
	logic [NCW-1:0] nc;
	logic [NRW-1:0] nr;
	logic [CW-1:0]  nc_m1;
	logic [RW-1:0]  nr_m1;
	logic [CW-1:0]  col_sat;
	logic [RW-1:0]  row_sat;
	logic [15:0]    blank;

	// execute-stage results
	logic [CW-1:0]    new_col;
	logic [NRW-1:0]   new_row;
	logic [CW:0]      tab_col;
	logic             put_we;
	logic [CW-1:0]    put_col;
	logic [NRW-1:0]   put_row;
	logic [15:0]      put_data;
	logic             scroll_need;
	logic [LIN_W-1:0] put_addr;
	logic [LIN_W-1:0] exec_pos;
	logic [LIN_W-1:0] fin_pos;
	logic [15:0]      exec_data;
	logic             rsp_free;
	logic             rsp_load;

	// RAM port
	logic              ram_we;
	logic [LIN_W-1:0]  ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [LIN_W-1:0]  ram_raddr;
	logic              ram_we_ok;
	logic              ram_re_ok;
	logic [15:0]       ram_rdata;

	always_comb begin
		if (cfg_cols_q == '0)
			nc = NCW'(1);
		else if (int'(cfg_cols_q) > MAX_COLUMNS)
			nc = NCW'(MAX_COLUMNS);
		else
			nc = NCW'(cfg_cols_q);
		if (cfg_rows_q == '0)
			nr = NRW'(1);
		else if (int'(cfg_rows_q) > MAX_ROWS)
			nr = NRW'(MAX_ROWS);
		else
			nr = NRW'(cfg_rows_q);
	end

	assign nc_m1   = CW'(nc - NCW'(1));
	assign nr_m1   = RW'(nr - NRW'(1));
	assign col_sat = (NCW'(col_q) >= nc) ? nc_m1 : col_q;
	assign row_sat = (NRW'(row_q) >= nr) ? nr_m1 : row_q;
	assign blank   = {cfg_attr_q, CH_SPACE};

	// Character interpretation on the saturated cursor
	always_comb begin
		new_col  = col_q;
		new_row  = NRW'(row_q);
		put_we   = 1'b0;
		put_data = blank;
		tab_col  = ({1'b0, col_q} + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
		if (kind_q == KIND_PUT) begin
			unique case (code_q)
				CH_BACKSPACE: begin
					// at home the cursor stays put and the home cell blanks
					if (col_q != '0) begin
						new_col = col_q - CW'(1);
					end else if (row_q != '0) begin
						new_col = nc_m1;
						new_row = NRW'(row_q) - NRW'(1);
					end
					put_we = 1'b1;
				end
				CH_TAB: begin
					if (int'(tab_col) >= int'(nc)) begin
						new_col = '0;
						new_row = NRW'(row_q) + NRW'(1);
					end else begin
						new_col = CW'(tab_col);
					end
				end
				CH_CR: begin
					new_col = '0;
				end
				CH_LF: begin
					new_col = '0;
					new_row = NRW'(row_q) + NRW'(1);
				end
				default: begin
					if (code_q >= CH_SPACE) begin
						put_we   = 1'b1;
						put_data = {cfg_attr_q, code_q};
						if (col_q >= nc_m1) begin
							new_col = '0;
							new_row = NRW'(row_q) + NRW'(1);
						end else begin
							new_col = col_q + CW'(1);
						end
					end
				end
			endcase
		end
		// backspace blanks the cell it lands on, a printable writes where it stood
		if (code_q == CH_BACKSPACE) begin
			put_col = new_col;
			put_row = new_row;
		end else begin
			put_col = col_q;
			put_row = NRW'(row_q);
		end
	end

	assign scroll_need = (kind_q == KIND_PUT) && (new_row >= nr);
	assign put_addr    = LIN_W'(put_row) * LIN_W'(nc) + LIN_W'(put_col);
	assign exec_pos    = LIN_W'(new_row) * LIN_W'(nc) + LIN_W'(new_col);
	assign fin_pos     = LIN_W'(row_q) * LIN_W'(nc) + LIN_W'(col_q);
	assign exec_data   = (kind_q == KIND_READ && !rd_oob_q) ? ram_rdata : 16'd0;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == ST_IDLE);

	// response register loads from execute (short words) or from finish
	assign rsp_load = rsp_free && ((state_q == ST_FINISH) ||
		(state_q == ST_EXEC && kind_q != KIND_CLEAR && !scroll_need));

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = blank;
		ram_re    = 1'b0;
		ram_raddr = ptr_q + LIN_W'(nc);
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = RESET_CELL;
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_re    = req_valid;
				ram_raddr = LIN_W'(req.cell_index);
			end
			ST_EXEC: begin
				ram_we    = put_we;
				ram_waddr = put_addr;
				ram_wdata = put_data;
			end
			ST_SCROLL: begin
				// lines move up; the tail of the walk blanks the bottom line
				ram_we    = s1_vld;
				ram_waddr = addr_s1;
				ram_wdata = copy_s1 ? (oob_s1 ? 16'd0 : ram_rdata) : blank;
				ram_re    = (ptr_q != span_q);
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// cells beyond the store are never written and read back as zero
	assign ram_we_ok = ram_we && (ram_waddr < LIN_W'(CELL_COUNT));
	assign ram_re_ok = ram_re && (ram_raddr < LIN_W'(CELL_COUNT));

	tcce_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we_ok),
		.waddr(ram_waddr[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re_ok),
		.raddr(ram_raddr[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			cfg_attr_q  <= RESET_ATTRIBUTE;
			cfg_cols_q  <= RESET_COLUMNS;
			cfg_rows_q  <= RESET_ROWS;
			cfg_shown_q <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			s1_vld      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ATTRIBUTE:    cfg_attr_q  <= cfg_wdata;
					REG_COLUMNS:      cfg_cols_q  <= cfg_wdata[6:0];
					REG_ROWS:         cfg_rows_q  <= cfg_wdata[4:0];
					REG_CURSOR_SHOWN: cfg_shown_q <= cfg_wdata[0];
				endcase
			end

			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_INIT: begin
					if (ptr_q == LIN_W'(CELL_COUNT - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + LIN_W'(1);
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						kind_q   <= req.kind;
						code_q   <= req.char_code;
						rd_oob_q <= !(LIN_W'(req.cell_index) < LIN_W'(CELL_COUNT));
						col_q    <= col_sat;
						row_q    <= row_sat;
						span_q   <= LIN_W'(nr) * LIN_W'(nc);
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					data_q <= exec_data;
					ptr_q  <= '0;
					if (kind_q == KIND_PUT) begin
						col_q <= new_col;
						row_q <= scroll_need ? nr_m1 : RW'(new_row);
					end
					if (kind_q == KIND_CLEAR) begin
						col_q   <= '0;
						row_q   <= '0;
						state_q <= ST_CLEAR;
					end else if (scroll_need) begin
						state_q <= ST_SCROLL;
					end else if (rsp_free) begin
						rsp_q.read_data       <= exec_data;
						rsp_q.cursor_position <= exec_pos[10:0];
						rsp_q.cursor_visible  <= cfg_shown_q;
						state_q               <= ST_IDLE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCROLL: begin
					if (ptr_q != span_q) begin
						s1_vld  <= 1'b1;
						addr_s1 <= ptr_q;
						copy_s1 <= (ptr_q < span_q - LIN_W'(nc));
						oob_s1  <= !ram_re_ok;
						ptr_q   <= ptr_q + LIN_W'(1);
					end else begin
						s1_vld  <= 1'b0;
						state_q <= ST_FINISH;
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + LIN_W'(1);
					if (ptr_q == LIN_W'(CELL_COUNT - 1))
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_free) begin
						rsp_q.read_data       <= data_q;
						rsp_q.cursor_position <= fin_pos[10:0];
						rsp_q.cursor_visible  <= cfg_shown_q;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// an accepted word always goes to the execute step next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ST_EXEC)
		else $error("accepted word did not enter execute");

	// the scroll write stage only lives inside a scroll walk
	a_s1_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld |-> state_q == ST_SCROLL)
		else $error("scroll stage valid outside scroll");

	// during scroll the write trails the read, never the same cell
	a_scroll_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL && ram_we_ok && ram_re_ok |-> ram_waddr != ram_raddr)
		else $error("scroll read and write hit the same cell");

	// a response is only produced by execute or finish
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_EXEC || $past(state_q) == ST_FINISH)
		else $error("response loaded from an unexpected state");

	// the store is left alone while waiting for a word
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we_ok)
		else $error("cell write while idle");
`endif

endmodule

// ===== tb/text_console_cell_engine_core_tb.sv =====
// Self-checking testbench for the text console cell engine: random and directed words against a behavioural screen model.
module text_console_cell_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcce_pkg::*;

	// Geometry of the instance; the predictor uses the same sizes
	localparam int CELLS     = 2048;
	localparam int MAX_COLS  = 80;
	localparam int MAX_LINES = 25;

	// The spare kind code; the block must leave everything as it is
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam int PHASES          = 12;
	localparam int WORDS_PER_PHASE = 150;

	// Screen scoreboard: keeps a behavioural copy of the screen store, the
	// cursor and the registers, predicts one response word per request word
	// and checks responses in order.
	class screen_scoreboard;
		logic [15:0] screen [CELLS];
		int unsigned col;
		int unsigned row;
		logic [7:0]  attr;
		logic [6:0]  cols_reg;
		logic [4:0]  rows_reg;
		logic        shown;
		rsp_word_t   expected_q [$];
		int unsigned mismatches;

		function new();
			attr       = RESET_ATTRIBUTE;
			cols_reg   = RESET_COLUMNS;
			rows_reg   = RESET_ROWS;
			shown      = 1'b1;
			col        = 0;
			row        = 0;
			mismatches = 0;
			foreach (screen[i]) screen[i] = RESET_CELL;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
			REG_ATTRIBUTE:    attr     = data;
			REG_COLUMNS:      cols_reg = data[6:0];
			REG_ROWS:         rows_reg = data[4:0];
			REG_CURSOR_SHOWN: shown    = data[0];
			default: ;
			endcase
		endfunction

		// Geometry in force: zero behaves as one, oversize as the maximum
		function int unsigned used_cols();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAX_COLS) return MAX_COLS;
			return cols_reg;
		endfunction

		function int unsigned used_rows();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_LINES) return MAX_LINES;
			return rows_reg;
		endfunction

		function logic [15:0] blank();
			return {attr, CH_SPACE};
		endfunction

		function void store(int unsigned addr, logic [15:0] v);
			if (addr < CELLS) screen[addr] = v;
		endfunction

		function logic [15:0] fetch(int unsigned addr);
			return (addr < CELLS) ? screen[addr] : 16'h0000;
		endfunction

		function void put_char(logic [7:0] code, int unsigned nc, int unsigned nr);
			int unsigned last;
			case (code)
			CH_BACKSPACE: begin
				// at home the cursor stays put, the cell still blanks
				if (col > 0) begin
					col--;
				end else if (row > 0) begin
					col = nc - 1;
					row--;
				end
				store(row * nc + col, blank());
			end
			CH_TAB: begin
				col = (col + TAB_STEP) & ~(TAB_STEP - 1);
				if (col >= nc) begin
					col = 0;
					row++;
				end
			end
			CH_CR: col = 0;
			CH_LF: begin
				col = 0;
				row++;
			end
			default: if (code >= CH_SPACE) begin
				store(row * nc + col, {attr, code});
				if (col >= nc - 1) begin
					col = 0;
					row++;
				end else begin
					col++;
				end
			end
			endcase
			// ran off the bottom: move everything up a line, blank the last
			if (row >= nr) begin
				last = (nr - 1) * nc;
				for (int unsigned i = 0; i < last; i++) store(i, fetch(i + nc));
				for (int unsigned i = 0; i < nc; i++) store(last + i, blank());
				row = nr - 1;
			end
		endfunction

		function rsp_word_t apply_word(req_word_t w);
			int unsigned nc;
			int unsigned nr;
			rsp_word_t   r;
			nc = used_cols();
			nr = used_rows();
			r  = '0;
			// cursor left outside by a geometry change is pulled back in
			if (col >= nc) col = nc - 1;
			if (row >= nr) row = nr - 1;
			case (w.kind)
			KIND_PUT:   put_char(w.char_code, nc, nr);
			KIND_READ:  r.read_data = fetch(w.cell_index);
			KIND_CLEAR: begin
				foreach (screen[i]) screen[i] = blank();
				col = 0;
				row = 0;
			end
			default: ;
			endcase
			r.cursor_position = 11'(row * nc + col);
			r.cursor_visible  = shown;
			return r;
		endfunction

		function void note_word(req_word_t w);
			expected_q.push_back(apply_word(w));
		endfunction

		task report(string msg);
			$display("%0t MISMATCH: %s", $time, msg);
			mismatches++;
		endtask

		task check_word(rsp_word_t got);
			rsp_word_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected response word %h", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
			if (got.cursor_position !== want.cursor_position)
				report($sformatf("cursor_position %0d, expected %0d",
					got.cursor_position, want.cursor_position));
			if (got.cursor_visible !== want.cursor_visible)
				report($sformatf("cursor_visible %b, expected %b",
					got.cursor_visible, want.cursor_visible));
		endtask
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	req_word_t  req       = '0;
	logic       rsp_ready = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = REG_ATTRIBUTE;
	logic [7:0] cfg_wdata = 8'h00;
	logic       req_ready;
	logic       rsp_valid;
	rsp_word_t  rsp;

	screen_scoreboard sb;

	// Idling percentages of the current phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	text_console_cell_engine_core #(
		.CELL_COUNT(CELLS),
		.MAX_COLUMNS(MAX_COLS),
		.MAX_ROWS(MAX_LINES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Response side: values sampled here are the ones before the edge, then
	// ready is redrawn for the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_word(rsp);
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Present one request word and hold it until taken. Valid only drops
	// when an idle gap is drawn, so it is never lowered and raised in one step.
	task send_word(req_word_t w);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_word(w);
	endtask

	// Hold off the sender until every expected response word is in
	task drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	// Write all four registers back to back with the enable held high
	task program_console(logic [7:0] a, logic [7:0] c, logic [7:0] r, logic [7:0] s);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ATTRIBUTE;
		cfg_wdata <= a;
		@(posedge clk);
		sb.write_reg(REG_ATTRIBUTE, a);
		cfg_index <= REG_COLUMNS;
		cfg_wdata <= c;
		@(posedge clk);
		sb.write_reg(REG_COLUMNS, c);
		cfg_index <= REG_ROWS;
		cfg_wdata <= r;
		@(posedge clk);
		sb.write_reg(REG_ROWS, r);
		cfg_index <= REG_CURSOR_SHOWN;
		cfg_wdata <= s;
		@(posedge clk);
		sb.write_reg(REG_CURSOR_SHOWN, s);
		cfg_we <= 1'b0;
	endtask

	function req_word_t word_of(logic [1:0] k, logic [7:0] code, logic [10:0] idx);
		req_word_t w;
		w.kind       = k;
		w.char_code  = code;
		w.cell_index = idx;
		return w;
	endfunction

	// Random request word: mostly puts, with control codes weighted up so
	// wraps, tabs and scrolls come often; reads mostly hit the screen in use.
	function req_word_t random_word();
		req_word_t   w;
		int unsigned roll;
		int unsigned area;
		w.cell_index = 11'($urandom_range(2047));
		w.char_code  = 8'($urandom_range(255));
		roll = $urandom_range(99);
		area = sb.used_cols() * sb.used_rows();
		if (roll < 2) begin
			w.kind = KIND_CLEAR;
		end else if (roll < 4) begin
			w.kind = KIND_NONE;
		end else if (roll < 18) begin
			w.kind = KIND_READ;
			if ($urandom_range(3) != 0) w.cell_index = 11'($urandom_range(area - 1));
		end else begin
			w.kind = KIND_PUT;
			roll = $urandom_range(99);
			if (roll < 6)       w.char_code = CH_BACKSPACE;
			else if (roll < 12) w.char_code = CH_TAB;
			else if (roll < 18) w.char_code = CH_LF;
			else if (roll < 23) w.char_code = CH_CR;
			else if (roll < 27) w.char_code = 8'($urandom_range(31));
			else                w.char_code = 8'($urandom_range(255, 32));
		end
		return w;
	endfunction

	// Words that do something: spare kinds and stray control codes don't count
	function bit does_work(req_word_t w);
		if (w.kind == KIND_NONE) return 1'b0;
		if (w.kind != KIND_PUT || w.char_code >= CH_SPACE) return 1'b1;
		return w.char_code == CH_BACKSPACE || w.char_code == CH_TAB ||
			w.char_code == CH_LF || w.char_code == CH_CR;
	endfunction

	initial begin
		req_word_t  w;
		int         done_words;
		logic [7:0] a_val;
		logic [7:0] c_val;
		logic [7:0] r_val;
		logic [7:0] s_val;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at reset geometry (80x25, colour 0x0F)
		send_word(word_of(KIND_READ, 8'h00, 11'd0));
		send_word(word_of(KIND_READ, 8'hFF, 11'd2047));
		send_word(word_of(KIND_PUT, CH_BACKSPACE, 11'd0));   // backspace at home
		send_word(word_of(KIND_PUT, CH_SPACE, 11'h7FF));     // lowest printable
		send_word(word_of(KIND_PUT, 8'hFF, 11'h000));        // highest printable
		send_word(word_of(KIND_PUT, CH_TAB, 11'd0));
		send_word(word_of(KIND_PUT, CH_CR, 11'd0));
		send_word(word_of(KIND_PUT, CH_LF, 11'd0));
		send_word(word_of(KIND_PUT, 8'h00, 11'd0));          // ignored controls
		send_word(word_of(KIND_PUT, 8'h1F, 11'd0));
		send_word(word_of(KIND_NONE, 8'hFF, 11'h7FF));       // spare kind
		send_word(word_of(KIND_READ, 8'h00, 11'd0));

		// Tiny 10x2 screen, odd colour, cursor hidden: edge wraps and scrolls
		drain();
		program_console(8'hA5, 8'd10, 8'd2, 8'h00);
		send_word(word_of(KIND_PUT, CH_TAB, 11'd0));
		send_word(word_of(KIND_PUT, CH_TAB, 11'd0));         // tab past the edge, scrolls
		send_word(word_of(KIND_PUT, CH_BACKSPACE, 11'd0));   // back onto previous line
		send_word(word_of(KIND_PUT, 8'h41, 11'd0));          // last column, wraps
		send_word(word_of(KIND_PUT, 8'h42, 11'd0));
		send_word(word_of(KIND_PUT, CH_LF, 11'd0));          // scroll
		send_word(word_of(KIND_READ, 8'h00, 11'd9));
		send_word(word_of(KIND_READ, 8'h00, 11'd0));
		send_word(word_of(KIND_CLEAR, 8'h00, 11'd0));
		send_word(word_of(KIND_READ, 8'h00, 11'd5));

		// Random phases, each with its own geometry and idling pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			a_val = 8'($urandom_range(255));
			s_val = 8'($urandom_range(255));
			case (phase)
			0: begin
				c_val = 8'd80;
				r_val = 8'd25;
				a_val = RESET_ATTRIBUTE;
			end
			1: begin
				// zero geometry acts as a single cell
				c_val = 8'd0;
				r_val = 8'd0;
				a_val = 8'h00;
			end
			2: begin
				// oversize geometry clamps to the maximum
				c_val = 8'hFF;
				r_val = 8'hFF;
				a_val = 8'hFF;
			end
			3: begin
				c_val = 8'd1;
				r_val = 8'd25;
			end
			4: begin
				c_val = 8'd80;
				r_val = 8'd1;
			end
			default: begin
				c_val = 8'($urandom_range(16, 2));
				r_val = 8'($urandom_range(6, 2));
				if ($urandom_range(3) == 0) c_val = 8'($urandom_range(255));
			end
			endcase
			program_console(a_val, c_val, r_val, s_val);

			case (phase % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 76;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct  = 14;
				recv_stall_pct = 14;
			end
			endcase

			done_words = 0;
			while (done_words < WORDS_PER_PHASE) begin
				w = random_word();
				// now and then let the block run completely dry
				if ($urandom_range(199) == 0) drain();
				send_word(w);
				if (does_work(w)) done_words++;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, scrolls and clears included
	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
